@@ rtl/bnms_pkg.sv @@
// Shared types and constants for the box non-maximum suppression block.
package bnms_pkg;

    localparam int MAX_BOXES  = 64;
    localparam int COORD_BITS = 12;
    localparam int SCORE_BITS = 16;
    localparam int THR_BITS   = 17;
    localparam int CNT_BITS   = $clog2(MAX_BOXES + 1);
    localparam int AREA_BITS  = 2 * COORD_BITS;
    localparam int SUM_BITS   = AREA_BITS + 1;
    localparam int PROD_BITS  = THR_BITS + SUM_BITS;
    localparam int FRAC_BITS  = 16;
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;

    localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(32768);
    localparam logic [1:0]          CMP_LAST  = 2'd3;

    typedef enum logic [0:0] {
        REG_IOU_THRESHOLD = 1'b0
    } reg_index_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] w;
        logic [COORD_BITS-1:0] h;
        logic [SCORE_BITS-1:0] score;
    } box_t;

    // what one cell shows its neighbors
    typedef struct packed {
        box_t box;
        logic valid;
        logic sup;
        logic ins;
    } cell_link_t;

    // commands broadcast along the row
    typedef struct packed {
        logic load;
        logic shift;
        logic mark;
        logic clear;
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_POP,
        ST_CMP,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/bnms_cell.sv @@
// One sorter cell: holds a box, inserts by score, tests overlap against the pivot.
module bnms_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  bnms_pkg::cell_ctl_t                 ctl,
    input  bnms_pkg::box_t                      in_box,
    input  bnms_pkg::box_t                      pivot,
    input  logic [bnms_pkg::AREA_BITS-1:0]      pivot_area,
    input  logic [bnms_pkg::THR_BITS-1:0]       thr,
    input  bnms_pkg::cell_link_t                left,
    input  bnms_pkg::cell_link_t                right,
    output bnms_pkg::cell_link_t                own
);

    bnms_pkg::box_t                        box_reg, box_next;
    logic                                  valid_reg, valid_next;
    logic                                  sup_reg, sup_next;
    logic                                  ins;
    logic [bnms_pkg::COORD_BITS:0]         xlo, xhi, ylo, yhi;
    logic [bnms_pkg::COORD_BITS-1:0]       iw, ih;
    logic [bnms_pkg::COORD_BITS-1:0]       iw_reg, ih_reg;
    logic [bnms_pkg::AREA_BITS-1:0]        carea_reg;
    logic [bnms_pkg::AREA_BITS-1:0]        inter_reg, inter3_reg;
    logic [bnms_pkg::SUM_BITS-1:0]         asum_reg, uni_reg;
    logic [bnms_pkg::PROD_BITS-1:0]        lhs, rhs;
    logic                                  over;

    // equal score does not displace: earlier box stays ahead
    assign ins = ctl.load && (!valid_reg || in_box.score > box_reg.score);

    always_comb begin
        xlo = (pivot.x > box_reg.x) ? {1'b0, pivot.x} : {1'b0, box_reg.x};
        ylo = (pivot.y > box_reg.y) ? {1'b0, pivot.y} : {1'b0, box_reg.y};
        xhi = ({1'b0, pivot.x} + {1'b0, pivot.w} < {1'b0, box_reg.x} + {1'b0, box_reg.w}) ?
              {1'b0, pivot.x} + {1'b0, pivot.w} : {1'b0, box_reg.x} + {1'b0, box_reg.w};
        yhi = ({1'b0, pivot.y} + {1'b0, pivot.h} < {1'b0, box_reg.y} + {1'b0, box_reg.h}) ?
              {1'b0, pivot.y} + {1'b0, pivot.h} : {1'b0, box_reg.y} + {1'b0, box_reg.h};
        iw  = (xhi > xlo) ? bnms_pkg::COORD_BITS'(xhi - xlo) : '0;
        ih  = (yhi > ylo) ? bnms_pkg::COORD_BITS'(yhi - ylo) : '0;
        lhs = bnms_pkg::PROD_BITS'({inter3_reg, {bnms_pkg::FRAC_BITS{1'b0}}});
        rhs = bnms_pkg::PROD_BITS'(thr) * bnms_pkg::PROD_BITS'(uni_reg);
        over = lhs > rhs;
    end

    always_comb begin
        box_next   = box_reg;
        valid_next = valid_reg;
        sup_next   = sup_reg;
        if (ctl.clear) begin
            valid_next = 1'b0;
            sup_next   = 1'b0;
        end else if (ctl.shift) begin
            box_next   = right.box;
            valid_next = right.valid;
            sup_next   = right.sup;
        end else if (left.ins) begin
            box_next   = left.box;
            valid_next = left.valid;
            sup_next   = 1'b0;
        end else if (ins) begin
            box_next   = in_box;
            valid_next = 1'b1;
            sup_next   = 1'b0;
        end else if (ctl.mark && valid_reg && over) begin
            sup_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sup_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            sup_reg   <= sup_next;
        end
    end

    // overlap pipeline runs freely; the sequencer samples it when settled
    always_ff @(posedge aclk) begin
        box_reg    <= box_next;
        iw_reg     <= iw;
        ih_reg     <= ih;
        carea_reg  <= bnms_pkg::AREA_BITS'(box_reg.w) * bnms_pkg::AREA_BITS'(box_reg.h);
        inter_reg  <= bnms_pkg::AREA_BITS'(iw_reg) * bnms_pkg::AREA_BITS'(ih_reg);
        asum_reg   <= bnms_pkg::SUM_BITS'(pivot_area) + bnms_pkg::SUM_BITS'(carea_reg);
        inter3_reg <= inter_reg;
        uni_reg    <= asum_reg - bnms_pkg::SUM_BITS'(inter_reg);
    end

    assign own.box   = box_reg;
    assign own.valid = valid_reg;
    assign own.sup   = sup_reg;
    assign own.ins   = ins || left.ins;

endmodule

@@ rtl/box_non_maximum_suppression.sv @@
// Top level: box load, sorting cell row, suppression sequencer and register port.
//
//  channel | direction | words
//  s_*     | in        | boxes, one per cycle while loading, set closed by s_last_box
//  m_*     | out       | surviving boxes in descending score, last one marked
//  p*      | in/out    | iou_threshold register at byte address 0
//
// While loading, the cell row keeps the set sorted as it fills.
// After the last box, each surviving box is popped, then waits while the overlap pipeline
// of the cells settles, then waits for the output; each suppressed box is only popped.
// Reset clears the row valid bits synchronously; no input is taken while a set drains.
// A stalled m_ready holds the word and the whole row.
module box_non_maximum_suppression (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bnms_pkg::PADDR_BITS-1:0]     paddr,
    input  logic [bnms_pkg::PDATA_BITS-1:0]     pwdata,
    output logic [bnms_pkg::PDATA_BITS-1:0]     prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bnms_pkg::COORD_BITS-1:0]     s_box_x,
    input  logic [bnms_pkg::COORD_BITS-1:0]     s_box_y,
    input  logic [bnms_pkg::COORD_BITS-1:0]     s_box_width,
    input  logic [bnms_pkg::COORD_BITS-1:0]     s_box_height,
    input  logic [bnms_pkg::SCORE_BITS-1:0]     s_box_score,
    input  logic                                s_last_box,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bnms_pkg::COORD_BITS-1:0]     m_kept_x,
    output logic [bnms_pkg::COORD_BITS-1:0]     m_kept_y,
    output logic [bnms_pkg::COORD_BITS-1:0]     m_kept_width,
    output logic [bnms_pkg::COORD_BITS-1:0]     m_kept_height,
    output logic [bnms_pkg::SCORE_BITS-1:0]     m_kept_score,
    output logic                                m_last_kept,
    output logic                                m_overflowed
);

    bnms_pkg::state_t                       state_reg, state_next;
    logic [1:0]                             ctr_reg, ctr_next;
    logic [bnms_pkg::CNT_BITS-1:0]          count_reg, count_next;
    logic                                   ovf_reg, ovf_next;
    logic [bnms_pkg::THR_BITS-1:0]          thr_reg;
    bnms_pkg::box_t                         pivot_reg;
    logic [bnms_pkg::AREA_BITS-1:0]         parea_reg;
    bnms_pkg::box_t                         in_box;
    bnms_pkg::cell_ctl_t                    ctl;
    bnms_pkg::cell_link_t                   links [bnms_pkg::MAX_BOXES];
    logic [bnms_pkg::MAX_BOXES-1:0]         alive;
    logic                                   s_acc, m_acc, full, none_alive, cfg_wr;

    assign in_box = '{x: s_box_x, y: s_box_y, w: s_box_width, h: s_box_height,
                      score: s_box_score};
    assign s_acc  = s_valid && s_ready;
    assign m_acc  = m_valid && m_ready;
    assign full   = (count_reg == bnms_pkg::CNT_BITS'(bnms_pkg::MAX_BOXES));

    genvar gi;
    generate
        for (gi = 0; gi < bnms_pkg::MAX_BOXES; gi++) begin : g_cell
            bnms_pkg::cell_link_t left_l, right_l;
            if (gi == 0) begin : g_first
                assign left_l = '0;
            end else begin : g_mid
                assign left_l = links[gi-1];
            end
            if (gi == bnms_pkg::MAX_BOXES - 1) begin : g_end
                assign right_l = '0;
            end else begin : g_inner
                assign right_l = links[gi+1];
            end
            bnms_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctl        (ctl),
                .in_box     (in_box),
                .pivot      (pivot_reg),
                .pivot_area (parea_reg),
                .thr        (thr_reg),
                .left       (left_l),
                .right      (right_l),
                .own        (links[gi])
            );
            assign alive[gi] = links[gi].valid && !links[gi].sup;
        end
    endgenerate

    assign none_alive = !(|alive);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bnms_pkg::ST_LOAD: if (s_acc && s_last_box) state_next = bnms_pkg::ST_POP;
            bnms_pkg::ST_POP:  if (!links[0].sup) state_next = bnms_pkg::ST_CMP;
            bnms_pkg::ST_CMP:  if (ctr_reg == bnms_pkg::CMP_LAST) state_next = bnms_pkg::ST_EMIT;
            bnms_pkg::ST_EMIT: if (m_ready) begin
                state_next = none_alive ? bnms_pkg::ST_LOAD : bnms_pkg::ST_POP;
            end
            default: state_next = bnms_pkg::ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_ready   = 1'b0;
        m_valid   = 1'b0;
        ctl       = '0;
        unique case (state_reg)
            bnms_pkg::ST_LOAD: begin
                s_ready  = 1'b1;
                ctl.load = s_acc && !full;
            end
            bnms_pkg::ST_POP:  ctl.shift = 1'b1;
            bnms_pkg::ST_CMP:  ctl.mark  = (ctr_reg == bnms_pkg::CMP_LAST);
            bnms_pkg::ST_EMIT: begin
                m_valid   = 1'b1;
                ctl.clear = m_ready && none_alive;
            end
            default: ;
        endcase
    end

    always_comb begin
        ctr_next   = (state_reg == bnms_pkg::ST_CMP) ? ctr_reg + 2'd1 : 2'd0;
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (ctl.load) count_next = count_reg + 1'b1;
        if (s_acc && full) ovf_next = 1'b1;
        if (ctl.clear) begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[2] == bnms_pkg::REG_IOU_THRESHOLD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bnms_pkg::ST_LOAD;
            ctr_reg   <= 2'd0;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            thr_reg   <= bnms_pkg::THR_RESET;
        end else begin
            state_reg <= state_next;
            ctr_reg   <= ctr_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_wr) thr_reg <= pwdata[bnms_pkg::THR_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == bnms_pkg::ST_POP && !links[0].sup) begin
            pivot_reg <= links[0].box;
            parea_reg <= bnms_pkg::AREA_BITS'(links[0].box.w) *
                         bnms_pkg::AREA_BITS'(links[0].box.h);
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bnms_pkg::REG_IOU_THRESHOLD) ?
                    bnms_pkg::PDATA_BITS'(thr_reg) : '0;

    assign m_kept_x      = pivot_reg.x;
    assign m_kept_y      = pivot_reg.y;
    assign m_kept_width  = pivot_reg.w;
    assign m_kept_height = pivot_reg.h;
    assign m_kept_score  = pivot_reg.score;
    assign m_last_kept   = none_alive;
    assign m_overflowed  = ovf_reg;

endmodule

@@ rtl/bnms_checker.sv @@
// Port-level checks for the box non-maximum suppression block, bound to the top.
module bnms_props (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_last_box,
    input logic m_valid,
    input logic m_ready,
    input logic m_last_kept,
    input logic [bnms_pkg::COORD_BITS-1:0] m_kept_x
);

    // input and output phases never overlap
    a_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a word is offered");

    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_box |=> !s_ready)
        else $error("input still open after the closing box");

    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_kept |=> !m_valid && s_ready)
        else $error("set did not end after its last word");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kept_x))
        else $error("stalled word changed");

endmodule

bind box_non_maximum_suppression bnms_props u_bnms_props (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_last_box  (s_last_box),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_last_kept (m_last_kept),
    .m_kept_x    (m_kept_x)
);

@@ tb/bnms_checker.sv @@
// Checker: watches the box and result channels, predicts surviving boxes and compares.
module bnms_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic [bnms_pkg::COORD_BITS-1:0] s_box_x,
    input  logic [bnms_pkg::COORD_BITS-1:0] s_box_y,
    input  logic [bnms_pkg::COORD_BITS-1:0] s_box_width,
    input  logic [bnms_pkg::COORD_BITS-1:0] s_box_height,
    input  logic [bnms_pkg::SCORE_BITS-1:0] s_box_score,
    input  logic                            s_last_box,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic [bnms_pkg::COORD_BITS-1:0] m_kept_x,
    input  logic [bnms_pkg::COORD_BITS-1:0] m_kept_y,
    input  logic [bnms_pkg::COORD_BITS-1:0] m_kept_width,
    input  logic [bnms_pkg::COORD_BITS-1:0] m_kept_height,
    input  logic [bnms_pkg::SCORE_BITS-1:0] m_kept_score,
    input  logic                            m_last_kept,
    input  logic                            m_overflowed,
    input  logic [bnms_pkg::THR_BITS-1:0]   iou_limit,
    output int                              fail_count,
    output int                              pending_count
);
    import bnms_pkg::*;

    typedef struct packed {
        box_t box;
        logic last;
        logic ovf;
    } kept_word_t;

    box_t       held_boxes[MAX_BOXES];
    int         held_count;
    logic       dropped;
    kept_word_t kept_queue[$];

    initial pending_count = 0;

    function automatic longint unsigned span(longint unsigned a0, longint unsigned al,
                                             longint unsigned b0, longint unsigned bl);
        longint unsigned lo, hi;
        lo = a0 > b0 ? a0 : b0;
        hi = (a0 + al) < (b0 + bl) ? (a0 + al) : (b0 + bl);
        return hi > lo ? hi - lo : 0;
    endfunction

    function automatic bit overlaps_too_much(box_t a, box_t b);
        longint unsigned iw, ih, inter, uni;
        iw = span(a.x, a.w, b.x, b.w);
        ih = span(a.y, a.h, b.y, b.h);
        inter = iw * ih;
        uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
        return inter * 65536 > longint'(iou_limit) * uni;
    endfunction

    task automatic predict_survivors();
        box_t ranked[MAX_BOXES];
        bit   gone[MAX_BOXES];
        int   j, lastpos;
        kept_word_t w;
        for (int i = 0; i < held_count; i++) begin
            j = i;
            while (j > 0 && ranked[j-1].score < held_boxes[i].score) begin
                ranked[j] = ranked[j-1];
                j--;
            end
            ranked[j] = held_boxes[i];
        end
        for (int i = 0; i < held_count; i++) gone[i] = 0;
        for (int i = 0; i < held_count; i++) begin
            if (!gone[i])
                for (int k = i + 1; k < held_count; k++)
                    if (!gone[k] && overlaps_too_much(ranked[i], ranked[k])) gone[k] = 1;
        end
        lastpos = 0;
        for (int i = 0; i < held_count; i++) if (!gone[i]) lastpos = i;
        for (int i = 0; i < held_count; i++) begin
            if (!gone[i]) begin
                w.box = ranked[i];
                w.last = (i == lastpos);
                w.ovf = dropped;
                kept_queue.push_back(w);
            end
        end
        held_count = 0;
        dropped = 0;
    endtask

    always @(posedge aclk) begin
        kept_word_t e;
        box_t b;
        if (!aresetn) begin
            held_count = 0;
            dropped = 0;
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (kept_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) $display("unexpected kept word x=%0d", m_kept_x);
                end else begin
                    e = kept_queue.pop_front();
                    if (m_kept_x !== e.box.x || m_kept_y !== e.box.y
                        || m_kept_width !== e.box.w || m_kept_height !== e.box.h
                        || m_kept_score !== e.box.score || m_last_kept !== e.last
                        || m_overflowed !== e.ovf) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display({"mismatch exp %0d %0d %0d %0d %0d l%0d o%0d",
                                      " got %0d %0d %0d %0d %0d l%0d o%0d"},
                                e.box.x, e.box.y, e.box.w, e.box.h, e.box.score, e.last,
                                e.ovf, m_kept_x, m_kept_y, m_kept_width, m_kept_height,
                                m_kept_score, m_last_kept, m_overflowed);
                    end
                end
            end
            if (s_valid && s_ready) begin
                b.x = s_box_x; b.y = s_box_y; b.w = s_box_width; b.h = s_box_height;
                b.score = s_box_score;
                if (held_count < MAX_BOXES) held_boxes[held_count++] = b;
                else dropped = 1;
                if (s_last_box) predict_survivors();
            end
        end
        pending_count = kept_queue.size();
    end
endmodule

@@ tb/tb_top.sv @@
// Testbench top: clock, reset, register writes, box stimulus and verdict.
module tb_top;
    import bnms_pkg::*;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [PADDR_BITS-1:0] paddr = '0;
    logic [PDATA_BITS-1:0] pwdata = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic pready;
    logic s_valid = 0, s_ready;
    logic [COORD_BITS-1:0] s_box_x = 0, s_box_y = 0, s_box_width = 0, s_box_height = 0;
    logic [SCORE_BITS-1:0] s_box_score = 0;
    logic s_last_box = 0;
    logic m_valid, m_ready = 0;
    logic [COORD_BITS-1:0] m_kept_x, m_kept_y, m_kept_width, m_kept_height;
    logic [SCORE_BITS-1:0] m_kept_score;
    logic m_last_kept, m_overflowed;
    logic [THR_BITS-1:0] iou_limit = THR_RESET;
    int fail_count, pending_count;
    int send_idle_pct = 0, recv_stall_pct = 0;
    int phase_no = 0;
    int hold_off = 0;
    logic hold_done = 0;
    longint cycles = 0;

    always #6 aclk = ~aclk;

    box_non_maximum_suppression u_top (.*);

    bnms_checker u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off in the last phase
    always @(posedge aclk) begin
        if (phase_no == 4 && !hold_done) begin
            hold_done <= 1;
            hold_off <= 600;
            m_ready <= 0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_limit(input int unsigned v);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= PADDR_BITS'(REG_IOU_THRESHOLD) << 2; pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        iou_limit <= v[THR_BITS-1:0];
    endtask

    task automatic drain();
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic send_box(input int x, y, w, h, s, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            @(posedge aclk);
            s_valid <= 0;
        end
        @(posedge aclk);
        s_valid <= 1;
        s_box_x <= COORD_BITS'(x); s_box_y <= COORD_BITS'(y);
        s_box_width <= COORD_BITS'(w); s_box_height <= COORD_BITS'(h);
        s_box_score <= SCORE_BITS'(s); s_last_box <= last;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 0;
    endtask

    // mostly small clustered sets so boxes overlap often
    task automatic random_set(input int n);
        int cx, cy;
        cx = $urandom_range(4095);
        cy = $urandom_range(4095);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0)
                send_box($urandom_range(4095), $urandom_range(4095),
                         $urandom_range(4095), $urandom_range(4095),
                         $urandom_range(65535), i == n - 1);
            else
                send_box((cx + $urandom_range(40)) & 12'hFFF,
                         (cy + $urandom_range(40)) & 12'hFFF,
                         $urandom_range(1, 120), $urandom_range(1, 120),
                         $urandom_range(3) == 0 ? 500 : $urandom_range(65535), i == n - 1);
        end
    endtask

    initial begin
        int sent;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        // directed: extremes, empty boxes, touching, equal scores, overflow
        send_box(0, 0, 0, 0, 0, 0);
        send_box(0, 0, 0, 5, 0, 0);
        send_box(4095, 4095, 4095, 4095, 65535, 0);
        send_box(10, 10, 10, 10, 7, 0);
        send_box(20, 10, 10, 10, 7, 0);
        send_box(12, 12, 10, 10, 7, 0);
        send_box(10, 10, 10, 10, 7, 1);
        send_box(100, 100, 50, 50, 9, 1);
        drain();
        write_limit(65536);
        send_box(10, 10, 10, 10, 7, 0);
        send_box(10, 10, 10, 10, 8, 1);
        drain();
        write_limit(0);
        send_box(10, 10, 10, 10, 7, 0);
        send_box(19, 19, 10, 10, 8, 0);
        send_box(20, 20, 10, 10, 9, 1);
        drain();
        write_limit(32768);
        // overflow: 66 boxes, the last two dropped, the last still closing the set
        for (int i = 0; i < 66; i++)
            send_box(i * 60, i * 60, 30, 30, $urandom_range(65535), i == 65);
        drain();
        sent = 0;
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 78; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 78; end
                3: begin send_idle_pct = 6; recv_stall_pct = 6; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            write_limit(ph == 4 ? 1 : $urandom_range(65536));
            phase_no = ph;
            while (sent < (ph + 1) * 78) begin
                int n;
                n = $urandom_range(9) == 0 ? $urandom_range(30, 64) : $urandom_range(1, 8);
                random_set(n);
                sent += n;
            end
            drain();
        end
        write_limit(32768);
        drain();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/bnms_pkg.sv
rtl/bnms_cell.sv
rtl/box_non_maximum_suppression.sv
rtl/bnms_checker.sv
tb/bnms_checker.sv
tb/tb_top.sv
